### src/u2a_pkg.sv
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and constants of the digit converter
// Mode codes, sequencer states, radix unit control and digit tables.
// ----------------------------------------------------------------------------
package u2a_pkg;

   localparam int DigitSlots = 16;
   localparam int DigitBits  = 4;
   localparam int CountBits  = 5;
   localparam int ValueBits  = 64;
   localparam int CharBits   = 7;

   // mode codes; bit 1 selects upper-case hex, so the unused code acts as upper hex
   localparam logic [1:0] MODE_DEC       = 2'd0;
   localparam logic [1:0] MODE_HEX_LOWER = 2'd1;
   localparam logic [1:0] MODE_HEX_UPPER = 2'd2;
   localparam int         ModeUpperBit   = 1;

   // divide by ten: q = (x * DecRecip) >> DecShift, exact for all 32-bit x
   localparam logic [31:0] DecRecip = 32'hCCCCCCCD;
   localparam int          DecShift = 35;

   localparam logic [CharBits-1:0] LowerDigits [DigitSlots] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102
   };
   localparam logic [CharBits-1:0] UpperDigits [DigitSlots] = '{
      7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SPLIT,
      ST_READ,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic dec;
      logic load;
   } ctrl_type;

   function automatic logic [CharBits-1:0] digit_ascii(input logic [DigitBits-1:0] d,
                                                      input logic upper);
      return upper ? UpperDigits[d] : LowerDigits[d];
   endfunction

endpackage

### src/u2a_ram.sv
// ----------------------------------------------------------------------------
// u2a_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module u2a_ram #(
   parameter int Width = 4,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/u2a_radix_unit.sv
// ----------------------------------------------------------------------------
// u2a_radix_unit: shared divide-by-radix step
// Splits the working value into quotient and low digit, radix 10 or 16.
// Radix 10 runs through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module u2a_radix_unit (
   input  logic                             clock,
   input  u2a_pkg::ctrl_type                ctrl,
   input  logic [u2a_pkg::ValueBits-1:0]    value,
   output logic [u2a_pkg::ValueBits-1:0]    quot,
   output logic [u2a_pkg::DigitBits-1:0]    rem
);

   logic [63:0]                          product_ff;
   logic [63:0]                          product_in;
   logic [63-u2a_pkg::DecShift:0]        dec_quot;
   logic [7:0]                           quot_x10;

   assign product_in = value[31:0] * u2a_pkg::DecRecip;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         product_ff <= product_in;
      end
   end

   assign dec_quot = product_ff[63:u2a_pkg::DecShift];
   // remainder is below ten, so the low nibble of x - 10q is enough
   assign quot_x10 = {4'd0, dec_quot[3:0]} * 8'd10;

   always_comb begin
      if (ctrl.dec) begin
         quot = {{u2a_pkg::DecShift{1'b0}}, dec_quot};
         rem  = value[3:0] - quot_x10[3:0];
      end else begin
         quot = {4'd0, value[u2a_pkg::ValueBits-1:4]};
         rem  = value[3:0];
      end
   end

endmodule

### src/unsigned_to_ascii_digits_core.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_core: unsigned value to ASCII digit characters
// Converts one value per transaction into its decimal or hex digits,
// most significant first, and marks the final character.
// ----------------------------------------------------------------------------
// One request transaction (mode, value) yields one response transaction per
// digit, most significant first, no leading zeros; zero gives a single '0'.
// Mode 0 converts the low 32 bits in decimal, mode 1 all 64 bits in lower-case
// hex, modes 2 and 3 in upper-case hex. The block takes one request at a time
// and holds req_ready low until the final character is taken. The block first
// accepts the request, then produces each digit by a reciprocal multiply and a
// split in decimal or by a split alone in hex, then fetches the first digit
// from the digit store, and then outputs one character per cycle while
// rsp_ready stays high.
// Every digit passes through the shared radix unit and the digit store.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [u2a_pkg::ValueBits-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u2a_pkg::CharBits-1:0]  rsp_digit_char,
   output logic                          rsp_last
);

   u2a_pkg::state_type                   state_ff, state_in;
   logic [u2a_pkg::ValueBits-1:0]        work_ff, work_in;
   logic [u2a_pkg::CountBits-1:0]        cnt_ff, cnt_in;
   logic [1:0]                           mode_ff, mode_in;
   logic [u2a_pkg::DigitBits-1:0]        idx_ff, idx_in;

   u2a_pkg::ctrl_type                    ctrl;
   logic [u2a_pkg::ValueBits-1:0]        quot;
   logic [u2a_pkg::DigitBits-1:0]        rem;
   logic                                 wr_en;
   logic                                 rd_en;
   logic [u2a_pkg::DigitBits-1:0]        rd_addr;
   logic [u2a_pkg::DigitBits-1:0]        rd_digit;
   logic                                 is_dec;

   assign is_dec = (mode_ff == u2a_pkg::MODE_DEC);

   // shared divide step
   u2a_radix_unit radix_unit (
      .clock (clock),
      .ctrl  (ctrl),
      .value (work_ff),
      .quot  (quot),
      .rem   (rem)
   );

   // digits, least significant first
   u2a_ram #(
      .Width (u2a_pkg::DigitBits),
      .Depth (u2a_pkg::DigitSlots)
   ) digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[u2a_pkg::DigitBits-1:0]),
      .wr_data (rem),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u2a_pkg::ST_IDLE;
         work_ff  <= '0;
         cnt_ff   <= '0;
         mode_ff  <= '0;
      end else begin
         state_ff <= state_in;
         work_ff  <= work_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
      idx_ff <= idx_in;
   end

   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      idx_in    = idx_ff;
      ctrl.dec  = is_dec;
      ctrl.load = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         u2a_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // latch the mode; decimal keeps the low 32 bits only
               mode_in = req_cmd;
               cnt_in  = '0;
               if (req_cmd == u2a_pkg::MODE_DEC) begin
                  work_in  = {32'd0, req_value[31:0]};
                  state_in = u2a_pkg::ST_MUL;
               end else begin
                  work_in  = req_value;
                  state_in = u2a_pkg::ST_SPLIT;
               end
            end
         end
         u2a_pkg::ST_MUL: begin
            // capture the reciprocal product for this digit
            ctrl.load = 1'b1;
            state_in  = u2a_pkg::ST_SPLIT;
         end
         u2a_pkg::ST_SPLIT: begin
            // store the low digit, advance to the quotient
            wr_en   = 1'b1;
            work_in = quot;
            cnt_in  = cnt_ff + u2a_pkg::CountBits'(1);
            if (quot == '0 || cnt_ff == u2a_pkg::CountBits'(u2a_pkg::DigitSlots - 1)) begin
               // most significant digit sits where this one was written
               idx_in   = cnt_ff[u2a_pkg::DigitBits-1:0];
               work_in  = '0;
               state_in = u2a_pkg::ST_READ;
            end else if (is_dec) begin
               state_in = u2a_pkg::ST_MUL;
            end else begin
               state_in = u2a_pkg::ST_SPLIT;
            end
         end
         u2a_pkg::ST_READ: begin
            // fetch the most significant digit
            rd_en    = 1'b1;
            state_in = u2a_pkg::ST_SHOW;
         end
         u2a_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == '0) begin
                  state_in = u2a_pkg::ST_IDLE;
               end else begin
                  // fetch the next digit while this one leaves
                  idx_in  = idx_ff - u2a_pkg::DigitBits'(1);
                  rd_addr = idx_in;
                  rd_en   = 1'b1;
               end
            end
         end
         default: begin
            state_in = u2a_pkg::ST_IDLE;
         end
      endcase
   end

   // character from the held digit; read data holds while stalled
   assign rsp_digit_char = u2a_pkg::digit_ascii(rd_digit, mode_ff[u2a_pkg::ModeUpperBit]);
   assign rsp_last       = (idx_ff == '0);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= u2a_pkg::CountBits'(u2a_pkg::DigitSlots))
      else $error("digit count beyond the digit store");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("block not ready after the final character");

   a_mul_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2a_pkg::ST_MUL) |=> (state_ff == u2a_pkg::ST_SPLIT))
      else $error("multiply not followed by a split");

   a_hex_no_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2a_pkg::ST_MUL) |-> is_dec)
      else $error("reciprocal multiply in a hex mode");
`endif

endmodule

### bench/digit_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_stream_checker: scoreboard for the digit converter
// Watches the request and response channels, predicts the characters of
// every accepted number and compares each response with the oldest one.
// ----------------------------------------------------------------------------
module digit_stream_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [u2a_pkg::ValueBits-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [u2a_pkg::CharBits-1:0]  rsp_digit_char,
   input  logic                          rsp_last,
   output int                            mismatch_count,
   output int                            chars_waiting,
   output int                            chars_checked
);

   localparam logic [u2a_pkg::CharBits-1:0] AsciiZero       = 7'd48;
   localparam logic [u2a_pkg::CharBits-1:0] AsciiUpperAlpha = 7'd55;  // 'A' - 10
   localparam logic [u2a_pkg::CharBits-1:0] AsciiLowerAlpha = 7'd87;  // 'a' - 10

   typedef struct packed {
      logic [u2a_pkg::CharBits-1:0] code;
      logic                         last;
   } digit_char_type;

   digit_char_type expected_chars [$];

   // split one number into digits and queue its characters, most significant first
   function automatic void queue_digits(input logic [1:0] cmd,
                                        input logic [u2a_pkg::ValueBits-1:0] value);
      logic [u2a_pkg::ValueBits-1:0] rest;
      logic [u2a_pkg::ValueBits-1:0] radix;
      logic [u2a_pkg::DigitBits-1:0] digits [u2a_pkg::DigitSlots];
      logic                          upper;
      digit_char_type                entry;
      int                            count;
      upper = cmd[u2a_pkg::ModeUpperBit];
      if (upper || cmd == u2a_pkg::MODE_HEX_LOWER) begin
         radix = 64'd16;
         rest  = value;
      end else begin
         radix = 64'd10;
         rest  = {32'd0, value[31:0]};
      end
      count = 0;
      do begin
         digits[count] = u2a_pkg::DigitBits'(rest % radix);
         rest = rest / radix;
         count++;
      end while (rest != 0 && count < u2a_pkg::DigitSlots);
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] < 10)
            entry.code = AsciiZero + u2a_pkg::CharBits'(digits[k]);
         else if (upper)
            entry.code = AsciiUpperAlpha + u2a_pkg::CharBits'(digits[k]);
         else
            entry.code = AsciiLowerAlpha + u2a_pkg::CharBits'(digits[k]);
         entry.last = (k == 0);
         expected_chars.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin : score_proc
      digit_char_type want;
      logic           bad;
      if (reset) begin
         expected_chars.delete();
         mismatch_count <= 0;
         chars_waiting  <= 0;
         chars_checked  <= 0;
      end else begin
         if (req_valid && req_ready)
            queue_digits(req_cmd, req_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: response char %0d last %0d arrived with nothing expected",
                        $time, rsp_digit_char, rsp_last);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_chars.pop_front();
               bad  = 1'b0;
               if (rsp_digit_char !== want.code) begin
                  $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                           $time, want.code, rsp_digit_char);
                  bad = 1'b1;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0d, actual %0d",
                           $time, want.last, rsp_last);
                  bad = 1'b1;
               end
               if (bad)
                  mismatch_count <= mismatch_count + 1;
               chars_checked <= chars_checked + 1;
            end
         end
         chars_waiting <= expected_chars.size();
      end
   end

endmodule

### bench/unsigned_to_ascii_digits_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_core_test: top of the digit converter bench
// Drives directed and random numbers in every mode, stalls both channels at
// random, and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits_core_test;

   // the spare mode code; the block treats it as upper-case hex
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int         HoldOffCycles = 300;
   localparam int         DrainCycles   = 40;
   localparam int         IdlePercent   = 7;
   localparam longint     TimeoutNs     = 64'd6_000_000;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_cmd        = u2a_pkg::MODE_DEC;
   logic [u2a_pkg::ValueBits-1:0] req_value      = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic [u2a_pkg::CharBits-1:0]  rsp_digit_char;
   logic                          rsp_last;

   logic                          hold_off_start = 1'b0;
   logic                          steady_phase   = 1'b0;
   int                            stall_left     = 0;
   int                            mismatch_count;
   int                            chars_waiting;
   int                            chars_checked;
   int                            dec_sent       = 0;
   int                            lower_sent     = 0;
   int                            upper_sent     = 0;
   int                            unused_sent    = 0;

   unsigned_to_ascii_digits_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   digit_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .chars_waiting  (chars_waiting),
      .chars_checked  (chars_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: a requested hold-off wins, then any stall still counting down,
   // then full speed in the steady phase, otherwise idle about 7% of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_start) begin
         rsp_ready  <= 1'b0;
         stall_left <= HoldOffCycles - 1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (steady_phase) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IdlePercent);
      end
   end

   // Offer one transaction and return at the edge that accepts it; valid stays
   // high so a following transaction can go out back to back.
   task automatic send_item(input logic [1:0] cmd,
                            input logic [u2a_pkg::ValueBits-1:0] value);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      case (cmd)
         u2a_pkg::MODE_DEC:       dec_sent++;
         u2a_pkg::MODE_HEX_LOWER: lower_sent++;
         u2a_pkg::MODE_HEX_UPPER: upper_sent++;
         default:                 unused_sent++;
      endcase
   endtask

   // Drop valid and let the request side sit idle.
   task automatic idle_cycles(input int count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted character has been taken.
   task automatic wait_drained();
      idle_cycles(1);
      while (chars_waiting != 0)
         @(posedge clock);
   endtask

   // Mix short, single-digit, zero and full-width numbers.
   function automatic logic [u2a_pkg::ValueBits-1:0] random_value();
      logic [u2a_pkg::ValueBits-1:0] v;
      int                            pick;
      v    = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick < 3)
         v = v >> $urandom_range(63);
      else if (pick == 3)
         v = v & 64'hF;
      else if (pick == 4)
         v = (v >> $urandom_range(63)) & 64'h0000_0000_FFFF_FFFF;
      else if (pick == 5 && $urandom_range(3) == 0)
         v = '0;
      return v;
   endfunction

   function automatic logic [1:0] random_mode();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4)
         return u2a_pkg::MODE_DEC;
      else if (pick < 7)
         return u2a_pkg::MODE_HEX_LOWER;
      else if (pick < 9)
         return u2a_pkg::MODE_HEX_UPPER;
      return MODE_UNUSED;
   endfunction

   task automatic send_random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if (!steady_phase && $urandom_range(99) < IdlePercent)
            idle_cycles($urandom_range(1, 4));
         send_item(random_mode(), random_value());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero in every mode, including the spare code
      send_item(u2a_pkg::MODE_DEC,       64'd0);
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'd0);
      send_item(u2a_pkg::MODE_HEX_UPPER, 64'd0);
      send_item(MODE_UNUSED,             64'd0);
      // decimal edges; high bits must be ignored
      send_item(u2a_pkg::MODE_DEC,       64'd9);
      send_item(u2a_pkg::MODE_DEC,       64'd10);
      send_item(u2a_pkg::MODE_DEC,       64'd1_000_000_000);
      send_item(u2a_pkg::MODE_DEC,       64'd1234567890);
      send_item(u2a_pkg::MODE_DEC,       64'h0000_0000_FFFF_FFFF);
      send_item(u2a_pkg::MODE_DEC,       64'hFFFF_FFFF_FFFF_FFFF);
      send_item(u2a_pkg::MODE_DEC,       64'h0000_0001_0000_0000);
      send_item(u2a_pkg::MODE_DEC,       64'hA5A5_A5A5_0000_002A);
      // hex edges and all letters in both cases
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'd15);
      send_item(u2a_pkg::MODE_HEX_UPPER, 64'd16);
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'h0123_4567_89AB_CDEF);
      send_item(u2a_pkg::MODE_HEX_UPPER, 64'h0123_4567_89AB_CDEF);
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(u2a_pkg::MODE_HEX_UPPER, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'h8000_0000_0000_0000);
      send_item(MODE_UNUSED,             64'hFEDC_BA98_7654_3210);
      send_item(MODE_UNUSED,             64'h0000_0000_00AB_CDEF);
      wait_drained();

      send_random_items(180);

      // Stall the receiver while the sender keeps offering, so the block backs
      // up and holds off its input, then pause until everything is out.
      req_valid      <= 1'b0;
      hold_off_start <= 1'b1;
      @(posedge clock);
      hold_off_start <= 1'b0;
      send_item(u2a_pkg::MODE_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
      send_random_items(4);
      wait_drained();

      // full speed on both sides
      steady_phase <= 1'b1;
      send_random_items(120);
      wait_drained();
      steady_phase <= 1'b0;

      send_random_items(180);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);

      $display("Converted %0d numbers: %0d decimal, %0d lower hex, %0d upper hex, %0d spare code",
               dec_sent + lower_sent + upper_sent + unused_sent,
               dec_sent, lower_sent, upper_sent, unused_sent);
      $display("Checked %0d characters, including a %0d-cycle receiver hold-off",
               chars_checked, HoldOffCycles);
      if (mismatch_count == 0 && chars_waiting == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(TimeoutNs);
      $display("Timeout with %0d characters still expected", chars_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### unsigned_to_ascii_digits_core.f
src/u2a_pkg.sv
src/u2a_ram.sv
src/u2a_radix_unit.sv
src/unsigned_to_ascii_digits_core.sv
bench/digit_stream_checker.sv
bench/unsigned_to_ascii_digits_core_test.sv
